// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/rc4_pkg.sv -----
package rc4_pkg;

    localparam int KEY_BYTES = 20;
    localparam int KEY_W     = KEY_BYTES * 8;
    localparam int KIDX_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    localparam int SBOX_AW   = 8;
    localparam int SBOX_DW   = 8;

    localparam int DROP_W    = 16;
    localparam logic [DROP_W-1:0] DROP_RESET = 16'd1024;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP     = 3'd3;

    localparam logic KIND_REKEY = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        logic [7:0] data;
        logic       not_keyed;
    } t_res;

    typedef struct packed {
        logic idle;
        logic res_valid;
        logic keyed;
    } t_eng_status;

endpackage

// ----- hw/rtl/rc4_keystream_cipher.sv -----
// Data byte: states RD_I, RD_J, WR_I, WR_J, the dependent accesses to the one-read, one-write port
// permutation memory per keystream byte; the next byte is taken only once the engine is back in idle.
// Byte before any rekey: passed through unchanged via ST_PASS, with o_not_keyed set.
// Rekey: fills all 256 entries, runs the key schedule over them, then drops drop_count bytes before idle.
// Reset clears control state, indices, keyed flag, key registers and output valid; drop_count resets to 1024.
// Permutation memory is not cleared on reset; the first rekey fills it.
`include "assert_macros.svh"

module rc4_keystream_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [7:0]                    i_data_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_data_out,
    output logic                          o_not_keyed,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rc4_pkg::CFG_DW-1:0]    i_cfg_data
);
    import rc4_pkg::*;

    logic [63:0]       r_key_low;
    logic [63:0]       r_key_mid;
    logic [31:0]       r_key_high;
    logic [DROP_W-1:0] r_drop_count;
    logic              r_out_valid;
    logic [7:0]        r_data_out;
    logic              r_not_keyed;

    logic [159:0]      w_key_all;
    logic              w_start;
    logic              w_out_free;
    logic              w_load;
    t_req              w_req;
    t_res              w_res;
    t_eng_status       w_status;

    assign w_key_all  = {r_key_high, r_key_mid, r_key_low};
    assign w_req.kind = i_kind;
    assign w_req.data = i_data_in;
    assign o_in_stall = !w_status.idle;
    assign w_start    = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = w_status.res_valid && w_out_free;
    assign o_cfg_ready = 1'b1;

    rc4_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_req        (w_req),
        .i_key        (w_key_all[KEY_W-1:0]),
        .i_drop_count (r_drop_count),
        .i_res_ready  (w_out_free),
        .o_res        (w_res),
        .o_status     (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_mid    <= '0;
            r_key_high   <= '0;
            r_drop_count <= DROP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low    <= i_cfg_data;
                CFG_KEY_MID:  r_key_mid    <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high   <= i_cfg_data[31:0];
                CFG_DROP:     r_drop_count <= i_cfg_data[DROP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data_out  <= w_res.data;
            r_not_keyed <= w_res.not_keyed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_not_keyed = r_not_keyed;

    `ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, w_start, o_in_stall, "engine idle after transfer")
    `ASSERT_IMPLIES(a_res_only_busy, i_clk, i_rst_n, w_status.res_valid, o_in_stall, "result while idle")
    `ASSERT_IMPLIES(a_keyed_no_flag, i_clk, i_rst_n, w_status.keyed && w_status.res_valid, !w_res.not_keyed, "pass-through after rekey")
    `ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, w_load, o_out_valid, "result lost")

endmodule

// ----- hw/rtl/rc4_sbox_ram.sv -----
module rc4_sbox_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [rc4_pkg::SBOX_AW-1:0] i_waddr,
    input  logic [rc4_pkg::SBOX_DW-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [rc4_pkg::SBOX_AW-1:0] i_raddr,
    output logic [rc4_pkg::SBOX_DW-1:0] o_rdata
);
    import rc4_pkg::*;

    logic [SBOX_DW-1:0] r_mem [2**SBOX_AW];
    logic [SBOX_DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rc4_engine.sv -----
module rc4_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  rc4_pkg::t_req              i_req,
    input  logic [rc4_pkg::KEY_W-1:0]  i_key,
    input  logic [rc4_pkg::DROP_W-1:0] i_drop_count,
    input  logic                       i_res_ready,
    output rc4_pkg::t_res              o_res,
    output rc4_pkg::t_eng_status       o_status
);
    import rc4_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_FILL = 7'b0000010,
        ST_RD_I = 7'b0000100,
        ST_RD_J = 7'b0001000,
        ST_WR_I = 7'b0010000,
        ST_WR_J = 7'b0100000,
        ST_PASS = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [SBOX_AW-1:0]  r_i, n_i;
    logic [SBOX_AW-1:0]  r_j, n_j;
    logic [SBOX_DW-1:0]  r_a, n_a;
    logic [SBOX_DW-1:0]  r_b, n_b;
    logic [KIDX_W-1:0]   r_kidx, n_kidx;
    logic [DROP_W-1:0]   r_drop, n_drop;
    logic                r_ksa, n_ksa;
    logic                r_is_data, n_is_data;
    logic                r_keyed, n_keyed;
    logic [7:0]          r_data, n_data;

    logic                w_we;
    logic [SBOX_AW-1:0]  w_waddr;
    logic [SBOX_DW-1:0]  w_wdata;
    logic                w_re;
    logic [SBOX_AW-1:0]  w_raddr;
    logic [SBOX_DW-1:0]  w_rdata;
    logic [7:0]          w_key_byte;
    logic [SBOX_AW-1:0]  w_i_addr;
    logic [SBOX_AW-1:0]  w_sum;
    logic [SBOX_DW-1:0]  w_ks;
    logic                w_res_valid;
    logic                w_not_keyed;

    rc4_sbox_ram u_sbox (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_key_byte = i_key[{r_kidx, 3'b000} +: 8];
    assign w_i_addr   = r_ksa ? r_i : r_i + SBOX_AW'(1);
    assign w_sum      = r_a + r_b;

    // forward the two swap writes that the registered read missed
    always_comb begin
        if (w_sum == r_j) begin
            w_ks = r_a;
        end else if (w_sum == r_i) begin
            w_ks = r_b;
        end else begin
            w_ks = w_rdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_b         = r_b;
        n_kidx      = r_kidx;
        n_drop      = r_drop;
        n_ksa       = r_ksa;
        n_is_data   = r_is_data;
        n_keyed     = r_keyed;
        n_data      = r_data;
        w_we        = 1'b0;
        w_waddr     = r_i;
        w_wdata     = r_i;
        w_re        = 1'b0;
        w_raddr     = w_i_addr;
        w_res_valid = 1'b0;
        w_not_keyed = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_data = i_req.data;
                    if (i_req.kind == KIND_REKEY) begin
                        n_is_data = 1'b0;
                        n_i       = '0;
                        n_state   = ST_FILL;
                    end else if (!r_keyed) begin
                        n_state = ST_PASS;
                    end else begin
                        n_is_data = 1'b1;
                        n_ksa     = 1'b0;
                        n_state   = ST_RD_I;
                    end
                end
            end
            ST_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_i;
                n_i     = r_i + SBOX_AW'(1);
                if (r_i == '1) begin
                    n_j     = '0;
                    n_kidx  = '0;
                    n_ksa   = 1'b1;
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                w_re    = 1'b1;
                w_raddr = w_i_addr;
                n_i     = w_i_addr;
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                n_a     = w_rdata;
                n_j     = r_j + w_rdata + (r_ksa ? w_key_byte : 8'd0);
                w_re    = 1'b1;
                w_raddr = n_j;
                n_state = ST_WR_I;
            end
            ST_WR_I: begin
                n_b     = w_rdata;
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rdata;
                w_re    = !r_ksa;
                w_raddr = r_a + w_rdata;
                n_state = ST_WR_J;
            end
            ST_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_a;
                if (r_ksa) begin
                    n_i    = r_i + SBOX_AW'(1);
                    n_kidx = (r_kidx == KIDX_W'(KEY_BYTES - 1)) ? '0 : r_kidx + KIDX_W'(1);
                    if (r_i == '1) begin
                        n_ksa   = 1'b0;
                        n_keyed = 1'b1;
                        n_j     = '0;
                        n_drop  = i_drop_count;
                        n_state = (i_drop_count == '0) ? ST_IDLE : ST_RD_I;
                    end else begin
                        n_state = ST_RD_I;
                    end
                end else if (r_is_data) begin
                    w_res_valid = 1'b1;
                    if (i_res_ready) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_drop  = r_drop - DROP_W'(1);
                    n_state = (r_drop == DROP_W'(1)) ? ST_IDLE : ST_RD_I;
                end
            end
            ST_PASS: begin
                w_res_valid = 1'b1;
                w_not_keyed = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_kidx    <= '0;
            r_drop    <= '0;
            r_ksa     <= 1'b0;
            r_is_data <= 1'b0;
            r_keyed   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_kidx    <= n_kidx;
            r_drop    <= n_drop;
            r_ksa     <= n_ksa;
            r_is_data <= n_is_data;
            r_keyed   <= n_keyed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_data <= n_data;
    end

    assign o_res.data          = w_not_keyed ? r_data : (r_data ^ w_ks);
    assign o_res.not_keyed     = w_not_keyed;
    assign o_status.idle       = (r_state == ST_IDLE);
    assign o_status.res_valid  = w_res_valid;
    assign o_status.keyed      = r_keyed;

endmodule
